// ===== rtl/acas_pkg.sv =====
// Shared widths, constants and the controller state type for the axis scaler.
package acas_pkg;

   // Sample and axis widths
   localparam int SAMPLE_BITS    = 12;
   localparam int AXIS_BITS      = 8;
   localparam int PROD_BITS      = SAMPLE_BITS + AXIS_BITS;
   localparam int REQ_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((AXIS_BITS + 7) / 8) * 8;
   localparam int CNT_BITS       = $clog2(AXIS_BITS);

   // Mark reset values
   localparam logic [SAMPLE_BITS-1:0] LOW_MARK_RESET  = {SAMPLE_BITS{1'b1}};
   localparam logic [SAMPLE_BITS-1:0] HIGH_MARK_RESET = '0;

   // Axis code for the bottom of the range (-128)
   localparam logic [AXIS_BITS-1:0] AXIS_MIN_CODE = {1'b1, {(AXIS_BITS-1){1'b0}}};

   // Last divide step count
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(AXIS_BITS - 1);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/auto_calibrating_axis_scaler_top.sv =====
// Auto calibrating scaler: running min/max marks and bit-serial scaling to int8.
// A request passes through PREP, MUL, DIV and DONE (DIV is skipped for an empty range);
// a new request is taken only in IDLE. The restoring divider retires one quotient bit
// per cycle, AXIS_BITS steps per request.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) sets low mark to all ones, high mark to zero,
// and empties the controller and the output register.
module auto_calibrating_axis_scaler_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [acas_pkg::REQ_TDATA_BITS-1:0]  req_tdata,  // [11:0] sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [acas_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,  // [7:0] axis_value
   output logic                                 rsp_tuser   // [0] range_empty
);
   import acas_pkg::*;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] low_ff, low_in;
   logic [SAMPLE_BITS-1:0] high_ff, high_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] span_ff;
   logic [SAMPLE_BITS-1:0] diff_ff;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [AXIS_BITS-1:0]   num_ff, num_in;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic                   empty_ff;
   logic [AXIS_BITS-1:0]   axis_ff;
   logic                   range_empty_ff;
   logic                   rsp_tvalid_ff;

   logic [SAMPLE_BITS-1:0] sample;
   logic                   accept;
   logic                   load_out;
   logic [PROD_BITS-1:0]   prod;
   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS:0]   trial_sub;
   logic                   trial_ge;

   assign sample = req_tdata[SAMPLE_BITS-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL: begin
            if (span_ff == '0) state_in = ST_DONE;
            else               state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs
   always_comb begin
      req_tready = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_DONE: load_out   = !rsp_tvalid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            load_out   = 1'b0;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Widen the marks with the new sample
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (sample < low_ff)  low_in  = sample;
      if (sample > high_ff) high_in = sample;
   end

   // Offset times 255 as (d << 8) - d; top bits seed the remainder
   assign prod = {diff_ff, {AXIS_BITS{1'b0}}} - {{AXIS_BITS{1'b0}}, diff_ff};

   // One restoring divide step: shift in next numerator bit, try subtract
   assign trial     = {rem_ff, num_ff[AXIS_BITS-1]};
   assign trial_sub = trial - {1'b0, span_ff};
   assign trial_ge  = trial >= {1'b0, span_ff};

   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      case (state_ff)
         ST_MUL: begin
            rem_in = prod[PROD_BITS-1:AXIS_BITS];
            num_in = prod[AXIS_BITS-1:0];
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            num_in = {num_ff[AXIS_BITS-2:0], trial_ge};
         end
         default: begin
            rem_in = rem_ff;
            num_in = num_ff;
         end
      endcase
   end

   // Control registers and marks
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         low_ff        <= LOW_MARK_RESET;
         high_ff       <= HIGH_MARK_RESET;
         rsp_tvalid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            low_ff  <= low_in;
            high_ff <= high_in;
         end
         if (state_ff == ST_DIV) cnt_ff <= cnt_ff + 1'b1;
         else                    cnt_ff <= '0;
         if (load_out)        rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) sample_ff <= sample;
      if (state_ff == ST_PREP) begin
         span_ff <= high_ff - low_ff;
         diff_ff <= sample_ff - low_ff;
      end
      if (state_ff == ST_MUL) empty_ff <= (span_ff == '0);
      rem_ff <= rem_in;
      num_ff <= num_in;
      // Quotient minus 128 is the quotient with its top bit flipped
      if (load_out) begin
         axis_ff        <= {~num_ff[AXIS_BITS-1], num_ff[AXIS_BITS-2:0]};
         range_empty_ff <= empty_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(axis_ff);
   assign rsp_tuser  = range_empty_ff;

   // Marks are ordered once a request is in flight
   a_marks_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (high_ff >= low_ff))
      else $error("high mark below low mark");

   // Divider remainder stays below the span
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < span_ff))
      else $error("divider remainder out of range");

   // A result only appears after the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   // Empty range always gives the bottom axis code
   a_empty_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && range_empty_ff) |-> (axis_ff == AXIS_MIN_CODE))
      else $error("empty range with nonzero axis offset");

endmodule
